// ----- hdl/md5_pkg.sv -----
// ---------------------------------------------------------------------------
// md5_pkg
// Item types, initial chaining values and round constants for the md5 core.
// ---------------------------------------------------------------------------
package md5_pkg;

    // input item: one little-endian message word
    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } t_md5_in;

    // output item: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        final_result;
    } t_md5_out;

    // initial chaining words a..d
    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    // pad byte placed right after the message
    localparam logic [31:0] PAD_BYTE = 32'h00000080;

    // buffer positions that hold the bit length
    localparam logic [3:0] POS_LEN_LO = 4'd14;
    localparam logic [3:0] POS_LEN_HI = 4'd15;

    // per-round additive constant
    function automatic logic [31:0] md5_sine(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h00000000;
        endcase
        return k;
    endfunction

    // rotate amount, indexed by {stage, round[1:0]}
    function automatic logic [4:0] md5_shift(input logic [3:0] idx);
        logic [4:0] s;
        case (idx)
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

// ----- hdl/md5_message_digest.sv -----
// a body word that does not close a block is stored in the buffer; a word that
// fills a block starts 64 rounds on the round unit, then a chaining-add step
// throughput: one shared round unit does one md5 step per cycle, input held meanwhile
// last word: padding one word per cycle, one or two blocks, then four digest items
// reset: synchronous active low, restores initial chaining words and clears counts
// ---------------------------------------------------------------------------
// md5_message_digest
// Iterative md5 core: buffers 16 words, runs 64 rounds on a shared round unit,
// pads the final block and returns the four digest words.
// ---------------------------------------------------------------------------
module md5_message_digest
    import md5_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_md5_in  i_item,
    output logic     o_stall,
    output logic     o_valid,
    output t_md5_out o_item,
    input  logic     i_stall
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_FINAL,
        S_OUT
    } t_state;

    t_state      r_state;
    logic [31:0] r_chain [4];
    logic [31:0] r_buf [16];
    logic [3:0]  r_pos;
    logic [63:0] r_bit_len;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_round;
    logic        r_need80;
    logic        r_lo_done;
    logic        r_padding;
    logic        r_finish;
    logic [1:0]  r_oidx;
    logic        r_out_valid;
    t_md5_out    r_out;

    logic        accept;
    logic [2:0]  cnt;
    logic [31:0] last_data;
    logic [31:0] pad_word;
    logic [31:0] f;
    logic [3:0]  g;
    logic [1:0]  stage;
    logic [31:0] sum;
    logic [31:0] rot;
    logic [4:0]  shamt;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // byte count clamp and the last message word, with the pad byte when it has room
    always_comb begin
        cnt = (i_item.byte_count > 3'd4) ? 3'd4 : i_item.byte_count;
        case (cnt[1:0])
            2'd1:    last_data = {16'h0000, 8'h80, i_item.message_word[7:0]};
            2'd2:    last_data = {8'h00, 8'h80, i_item.message_word[15:0]};
            2'd3:    last_data = {8'h80, i_item.message_word[23:0]};
            default: last_data = PAD_BYTE;
        endcase
        if (cnt == 3'd4) begin
            last_data = i_item.message_word;
        end
    end

    // padding word for the current buffer position
    always_comb begin
        if (r_need80) begin
            pad_word = PAD_BYTE;
        end else if (r_pos == POS_LEN_LO) begin
            pad_word = r_bit_len[31:0];
        end else if (r_pos == POS_LEN_HI && r_lo_done) begin
            pad_word = r_bit_len[63:32];
        end else begin
            pad_word = 32'h00000000;
        end
    end

    // shared round unit
    always_comb begin
        stage = r_round[5:4];
        case (stage)
            2'd0: begin
                f = (r_b & r_c) | (~r_b & r_d);
                g = r_round[3:0];
            end
            2'd1: begin
                f = (r_d & r_b) | (~r_d & r_c);
                g = 4'(r_round[3:0] * 4'd5 + 4'd1);
            end
            2'd2: begin
                f = r_b ^ r_c ^ r_d;
                g = 4'(r_round[3:0] * 4'd3 + 4'd5);
            end
            default: begin
                f = r_c ^ (r_b | ~r_d);
                g = 4'(r_round[3:0] * 4'd7);
            end
        endcase
        shamt = md5_shift({stage, r_round[1:0]});
        sum   = r_a + f + md5_sine(r_round) + r_buf[g];
        rot   = 32'(({sum, sum} << shamt) >> 32);
    end

    // sequencer, buffer, chaining words and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chain[0]  <= INIT_A;
            r_chain[1]  <= INIT_B;
            r_chain[2]  <= INIT_C;
            r_chain[3]  <= INIT_D;
            r_pos       <= 4'd0;
            r_bit_len   <= 64'd0;
            r_round     <= 6'd0;
            r_need80    <= 1'b0;
            r_lo_done   <= 1'b0;
            r_padding   <= 1'b0;
            r_finish    <= 1'b0;
            r_oidx      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            // output register drains outside the digest phase
            if (r_out_valid && !i_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_pos <= r_pos + 4'd1;
                        r_a   <= r_chain[0];
                        r_b   <= r_chain[1];
                        r_c   <= r_chain[2];
                        r_d   <= r_chain[3];
                        if (!i_item.last_word) begin
                            r_buf[r_pos] <= i_item.message_word;
                            r_bit_len    <= r_bit_len + 64'd32;
                            r_padding    <= 1'b0;
                            if (r_pos == 4'd15) begin
                                r_state <= S_ROUND;
                            end
                        end else begin
                            r_buf[r_pos] <= last_data;
                            r_bit_len    <= r_bit_len + {58'd0, cnt, 3'b000};
                            r_need80     <= (cnt == 3'd4);
                            r_padding    <= 1'b1;
                            r_state      <= (r_pos == 4'd15) ? S_ROUND : S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_buf[r_pos] <= pad_word;
                    r_pos        <= r_pos + 4'd1;
                    r_need80     <= 1'b0;
                    r_a          <= r_chain[0];
                    r_b          <= r_chain[1];
                    r_c          <= r_chain[2];
                    r_d          <= r_chain[3];
                    if (r_pos == POS_LEN_LO && !r_need80) begin
                        r_lo_done <= 1'b1;
                    end
                    if (r_pos == POS_LEN_HI) begin
                        r_state <= S_ROUND;
                        if (r_lo_done && !r_need80) begin
                            r_finish <= 1'b1;
                        end
                    end
                end
                S_ROUND: begin
                    r_a     <= r_d;
                    r_d     <= r_c;
                    r_c     <= r_b;
                    r_b     <= r_b + rot;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    r_chain[0] <= r_chain[0] + r_a;
                    r_chain[1] <= r_chain[1] + r_b;
                    r_chain[2] <= r_chain[2] + r_c;
                    r_chain[3] <= r_chain[3] + r_d;
                    r_oidx     <= 2'd0;
                    if (r_finish) begin
                        r_state <= S_OUT;
                    end else if (r_padding) begin
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    // hand out one digest word each time the output register frees
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid        <= 1'b1;
                        r_out.digest_word  <= r_chain[r_oidx];
                        r_out.word_index   <= r_oidx;
                        r_out.final_result <= (r_oidx == 2'd3);
                        r_oidx             <= r_oidx + 2'd1;
                        if (r_oidx == 2'd3) begin
                            r_state    <= S_IDLE;
                            r_chain[0] <= INIT_A;
                            r_chain[1] <= INIT_B;
                            r_chain[2] <= INIT_C;
                            r_chain[3] <= INIT_D;
                            r_pos      <= 4'd0;
                            r_bit_len  <= 64'd0;
                            r_lo_done  <= 1'b0;
                            r_padding  <= 1'b0;
                            r_finish   <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // round counter rests at zero outside the round loop
    a_round_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ROUND) |-> (r_round == 6'd0))
        else $error("round counter not at zero outside rounds");

    // the last digest item and only it carries the final flag
    a_final_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.final_result == (o_item.word_index == 2'd3)))
        else $error("final flag does not match word index");

    // the pad byte always goes in before the length words
    a_pad_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_need80 |-> !r_lo_done)
        else $error("length written before pad byte");

    // digest items are only produced after a finished message
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> r_finish)
        else $error("digest output without a finished message");
`endif

endmodule

// ----- dv/tb_md5_message_digest.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_md5_message_digest
// Self-checking bench for the md5 core. Messages go in as word items with
// random idling and output stalls; an in-bench md5 predictor computes the four
// digest words of each message and every output item is checked in order.
// ---------------------------------------------------------------------------
module tb_md5_message_digest;
    import md5_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 255;
    localparam int QUIET_TAIL   = 40;

    // md5 additive constants, step 0 in the top word
    localparam logic [64*32-1:0] STEP_CONST = {
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // rotate amounts per stage and step within a group of four
    localparam logic [16*5-1:0] ROT_AMOUNT = {
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    t_md5_in  i_item  = '0;
    logic     i_stall = 1'b0;
    logic     o_stall;
    logic     o_valid;
    t_md5_out o_item;

    md5_message_digest i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_item  (o_item),
        .i_stall (i_stall)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [31:0] chain_q [4];
    logic [31:0] block_q [16];
    logic [3:0]  fill_pos;
    logic [63:0] msg_bits;

    t_md5_out pending_digest [$];
    t_md5_out want_digest;

    int errors          = 0;
    int items_sent      = 0;
    int messages_sent   = 0;
    int digests_checked = 0;
    int cycle_count     = 0;
    bit quiet_phase     = 1'b0;

    // ------------------------------------------------------------------
    // md5 predictor
    // ------------------------------------------------------------------
    function automatic void restart_digest();
        chain_q[0] = INIT_A;
        chain_q[1] = INIT_B;
        chain_q[2] = INIT_C;
        chain_q[3] = INIT_D;
        fill_pos   = '0;
        msg_bits   = '0;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void compress_block();
        logic [31:0] a, b, c, d, f, t;
        int g, stage;
        a = chain_q[0];
        b = chain_q[1];
        c = chain_q[2];
        d = chain_q[3];
        for (int i = 0; i < 64; i++) begin
            stage = i >> 4;
            case (stage)
                0: begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1: begin
                    f = (d & b) | (~d & c);
                    g = (5 * i + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            t = d;
            d = c;
            c = b;
            b = b + rotl(a + f + STEP_CONST[(63 - i) * 32 +: 32] + block_q[g],
                         ROT_AMOUNT[(15 - (stage * 4 + i % 4)) * 5 +: 5]);
            a = t;
        end
        chain_q[0] = chain_q[0] + a;
        chain_q[1] = chain_q[1] + b;
        chain_q[2] = chain_q[2] + c;
        chain_q[3] = chain_q[3] + d;
    endfunction

    function automatic void absorb_word(input logic [31:0] w);
        block_q[fill_pos] = w;
        fill_pos = fill_pos + 4'd1;
        if (fill_pos == 4'd0) begin
            compress_block();
        end
    endfunction

    // fold one accepted item in; a last word closes the message and queues the digest
    function automatic void predict_digest(input t_md5_in item);
        int          count;
        logic [31:0] mask;
        t_md5_out    digest_item;
        if (!item.last_word) begin
            msg_bits = msg_bits + 64'd32;
            absorb_word(item.message_word);
            return;
        end
        count = (item.byte_count > 3'd4) ? 4 : int'(item.byte_count);
        msg_bits = msg_bits + 64'(count * 8);
        if (count == 4) begin
            absorb_word(item.message_word);
            absorb_word(PAD_BYTE);
        end else begin
            mask = (count == 0) ? 32'h0 : (32'hffffffff >> (32 - 8 * count));
            absorb_word((item.message_word & mask) | (PAD_BYTE << (8 * count)));
        end
        while (fill_pos != POS_LEN_LO) begin
            absorb_word(32'h0);
        end
        absorb_word(msg_bits[31:0]);
        absorb_word(msg_bits[63:32]);
        for (int k = 0; k < 4; k++) begin
            digest_item.digest_word  = chain_q[k];
            digest_item.word_index   = 2'(k);
            digest_item.final_result = (k == 3);
            pending_digest.push_back(digest_item);
        end
        restart_digest();
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    task automatic send_item(input t_md5_in item, input int gap_pct);
        if (!quiet_phase && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= item;
        do @(posedge i_clk); while (o_stall);
        predict_digest(item);
        items_sent++;
        if (item.last_word) begin
            messages_sent++;
        end
    endtask

    task automatic send_message(input int body_words, input int gap_pct);
        t_md5_in item;
        for (int n = 0; n < body_words; n++) begin
            item.message_word = $urandom();
            item.byte_count   = 3'($urandom_range(0, 7));
            item.last_word    = 1'b0;
            send_item(item, gap_pct);
        end
        case ($urandom_range(0, 7))
            0:       item.message_word = 32'h00000000;
            1:       item.message_word = 32'hffffffff;
            default: item.message_word = $urandom();
        endcase
        item.byte_count = 3'($urandom_range(0, 7));
        item.last_word  = 1'b1;
        send_item(item, gap_pct);
    endtask

    // ------------------------------------------------------------------
    // output side: random stall bursts, none in the quiet tail
    // ------------------------------------------------------------------
    initial begin : result_backpressure
        int run;
        forever begin
            run = $urandom_range(1, 30);
            repeat (run) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
            if (!quiet_phase) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
        end
    end

    // compare each accepted digest item with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_digest.size() == 0) begin
                errors++;
                $display("%0t: unexpected digest item word=%h index=%0d last=%0d",
                         $time, o_item.digest_word, o_item.word_index, o_item.final_result);
            end else begin
                want_digest = pending_digest.pop_front();
                digests_checked++;
                if (o_item.digest_word  !== want_digest.digest_word ||
                    o_item.word_index   !== want_digest.word_index ||
                    o_item.final_result !== want_digest.final_result) begin
                    errors++;
                    $display("%0t: digest mismatch expected %h/%0d/%0d actual %h/%0d/%0d",
                             $time, want_digest.digest_word, want_digest.word_index,
                             want_digest.final_result, o_item.digest_word,
                             o_item.word_index, o_item.final_result);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // empty message: count zero on a last word, data bytes ignored
    task automatic test_empty_message();
        t_md5_in item;
        item.message_word = 32'hffffffff;
        item.byte_count   = 3'd0;
        item.last_word    = 1'b1;
        send_item(item, 0);
    endtask

    // one to three byte messages, unused bytes all ones
    task automatic test_partial_tails();
        t_md5_in item;
        for (int cnt = 1; cnt <= 3; cnt++) begin
            item.message_word = 32'hffffffff;
            item.byte_count   = 3'(cnt);
            item.last_word    = 1'b1;
            send_item(item, 30);
        end
    endtask

    // counts five to seven on a last word behave as four
    task automatic test_oversize_counts();
        t_md5_in item;
        for (int cnt = 5; cnt <= 7; cnt++) begin
            item.message_word = $urandom();
            item.byte_count   = 3'(cnt);
            item.last_word    = 1'b1;
            send_item(item, 30);
        end
    endtask

    // full last word at position 13 pushes the length into a second block;
    // body words carry every byte count, which must all be taken as four
    task automatic test_two_block_padding();
        t_md5_in item;
        for (int n = 0; n < 13; n++) begin
            item.message_word = n[0] ? 32'hffffffff : 32'h00000000;
            item.byte_count   = 3'(n % 8);
            item.last_word    = 1'b0;
            send_item(item, 30);
        end
        item.message_word = 32'hffffffff;
        item.byte_count   = 3'd4;
        item.last_word    = 1'b1;
        send_item(item, 30);
    endtask

    // random messages, mostly within one or two blocks, some a few blocks long
    task automatic test_random_messages();
        int target, body_words, gap_pct;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            quiet_phase = (items_sent >= target - QUIET_TAIL);
            body_words  = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 48)
                                                      : $urandom_range(0, 16);
            gap_pct     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
            send_message(body_words, gap_pct);
        end
    endtask

    // ------------------------------------------------------------------
    // run control
    // ------------------------------------------------------------------
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout, %0d digest words outstanding", $time, pending_digest.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        restart_digest();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_message();
        test_partial_tails();
        test_oversize_counts();
        test_two_block_padding();
        test_random_messages();

        i_valid <= 1'b0;
        while (pending_digest.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("run covered %0d message words in %0d messages (empty, partial, oversize,",
                 items_sent, messages_sent);
        $display("two-block padding, random lengths); %0d digest words checked, %0d errors",
                 digests_checked, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
